### rtl/core/abdc_pkg.sv
package abdc_pkg;

   localparam int WINDOW     = 4096;
   localparam int FILES      = 4;
   localparam int NCOUNTS    = 6;
   localparam int CNT_W      = 16;
   localparam int ROWS       = WINDOW * FILES;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int ROW_BITS   = NCOUNTS * CNT_W;
   localparam int LANE_W     = $clog2(NCOUNTS);
   localparam int CURSOR_W   = 32;
   localparam int MODE_W     = 3;
   localparam int FILE_W     = 2;
   localparam int POS_W      = 31;
   localparam int QUAL_W     = 8;
   localparam int CIGAR_W    = 4;
   localparam int OPLEN_W    = 28;
   localparam int BASE_W     = 4;
   localparam int REGION_W   = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [REGION_W-1:0] REGION_RESET = 13'd4096;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_QUALITY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_LENGTH = 1'b1;

   localparam logic [MODE_W-1:0] MODE_START = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CIGAR = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BASE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

   localparam logic [CIGAR_W-1:0] CIG_M  = 4'd0;
   localparam logic [CIGAR_W-1:0] CIG_I  = 4'd1;
   localparam logic [CIGAR_W-1:0] CIG_D  = 4'd2;
   localparam logic [CIGAR_W-1:0] CIG_N  = 4'd3;
   localparam logic [CIGAR_W-1:0] CIG_S  = 4'd4;
   localparam logic [CIGAR_W-1:0] CIG_EQ = 4'd7;
   localparam logic [CIGAR_W-1:0] CIG_X  = 4'd8;

   localparam logic [BASE_W-1:0] BASE_A = 4'd1;
   localparam logic [BASE_W-1:0] BASE_C = 4'd2;
   localparam logic [BASE_W-1:0] BASE_G = 4'd4;
   localparam logic [BASE_W-1:0] BASE_T = 4'd8;
   localparam logic [BASE_W-1:0] BASE_N = 4'd15;

   localparam logic [LANE_W-1:0] LANE_A     = 3'd0;
   localparam logic [LANE_W-1:0] LANE_T     = 3'd1;
   localparam logic [LANE_W-1:0] LANE_C     = 3'd2;
   localparam logic [LANE_W-1:0] LANE_G     = 3'd3;
   localparam logic [LANE_W-1:0] LANE_N     = 3'd4;
   localparam logic [LANE_W-1:0] LANE_OTHER = 3'd5;

   typedef logic [CNT_W-1:0] count_type;
   typedef count_type [NCOUNTS-1:0] row_type;

   typedef enum logic [1:0] {
      S2_NONE,
      S2_INC,
      S2_READ,
      S2_CLEAR
   } s2_op_type;

   function automatic logic is_match(input logic [CIGAR_W-1:0] code);
      return code inside {CIG_M, CIG_EQ, CIG_X};
   endfunction

   function automatic logic [LANE_W-1:0] base_lane(input logic [BASE_W-1:0] code);
      logic [LANE_W-1:0] lane;
      case (code)
         BASE_A:  lane = LANE_A;
         BASE_T:  lane = LANE_T;
         BASE_C:  lane = LANE_C;
         BASE_G:  lane = LANE_G;
         BASE_N:  lane = LANE_N;
         default: lane = LANE_OTHER;
      endcase
      return lane;
   endfunction

   function automatic logic [ROW_W-1:0] row_of(input logic [CURSOR_W-1:0] pos,
                                               input logic [FILE_W-1:0]   file);
      return ROW_W'(ROW_W'(pos) * ROW_W'(FILES) + ROW_W'(file));
   endfunction

endpackage

### rtl/core/abdc_count_ram.sv
module abdc_count_ram #(
   parameter int DEPTH  = 16384,
   parameter int WIDTH  = 96,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/aligned_base_depth_counter_unit.sv
// channel  | ports            | direction | handshake
// ---------+------------------+-----------+---------------------------------
// request  | req_*            | in        | req_valid / req_stall
// response | rsp_*            | out       | rsp_valid / rsp_stall
// config   | csr_*            | in        | csr_write_enable, no wait
//
// One item per cycle while req_stall is low; a count read occupies the count
// memory read port and holds the request side until its response registers.
// Each counted base does one read-modify-write of a memory row; back-to-back bases on
// the same row forward the pending write data.
// After reset a clearing pass zeroes all 16384 rows of the count memory, one row
// per cycle, with req_stall high. Config writes are taken throughout.
// A response held by rsp_stall holds the request side.
module aligned_base_depth_counter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [abdc_pkg::MODE_W-1:0]     req_mode,
   input  logic [abdc_pkg::FILE_W-1:0]     req_file_index,
   input  logic [abdc_pkg::POS_W-1:0]      req_position,
   input  logic [abdc_pkg::QUAL_W-1:0]     req_map_quality,
   input  logic [abdc_pkg::CIGAR_W-1:0]    req_cigar_code,
   input  logic [abdc_pkg::OPLEN_W-1:0]    req_op_length,
   input  logic [abdc_pkg::BASE_W-1:0]     req_base_code,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [abdc_pkg::CNT_W-1:0]      rsp_count_a,
   output logic [abdc_pkg::CNT_W-1:0]      rsp_count_t,
   output logic [abdc_pkg::CNT_W-1:0]      rsp_count_c,
   output logic [abdc_pkg::CNT_W-1:0]      rsp_count_g,
   output logic [abdc_pkg::CNT_W-1:0]      rsp_count_n,
   output logic [abdc_pkg::CNT_W-1:0]      rsp_count_other,
   output logic                            rsp_in_window,
   input  logic                            csr_write_enable,
   input  logic [abdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [abdc_pkg::CSR_DATA_W-1:0] csr_write_data
);

   import abdc_pkg::*;

   logic [QUAL_W-1:0]   min_quality_ff;
   logic [REGION_W-1:0] region_length_ff;

   logic [CURSOR_W-1:0] cursor_ff, cursor_in;
   logic [FILE_W-1:0]   read_file_ff, read_file_in;
   logic                read_skipped_ff, read_skipped_in;
   logic [CIGAR_W-1:0]  op_kind_ff, op_kind_in;
   logic [OPLEN_W-1:0]  op_remaining_ff, op_remaining_in;

   logic                clr_active_ff, clr_active_in;
   logic [ROW_W-1:0]    clr_row_ff, clr_row_in;

   s2_op_type           s2_op_ff, s2_op_in;
   logic [ROW_W-1:0]    s2_row_ff, s2_row_in;
   logic [LANE_W-1:0]   s2_lane_ff, s2_lane_in;
   logic                s2_win_ff, s2_win_in;
   logic                s2_fwd_ff, s2_fwd_in;
   row_type             last_wr_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   row_type             rsp_row_ff;
   logic                rsp_win_ff;

   logic [REGION_W-1:0] limit;
   logic                accept;
   logic                cur_win;
   logic                req_win;
   logic                rd_en;
   logic                wr_en;
   logic [ROW_W-1:0]    wr_addr;
   row_type             wr_data;
   row_type             rd_data;
   row_type             row_cur;
   row_type             row_new;

   assign limit = (region_length_ff > REGION_W'(WINDOW)) ? REGION_W'(WINDOW)
                                                          : region_length_ff;

   assign cur_win = (cursor_ff < CURSOR_W'(limit))
                 && ((FILE_W + 1)'(read_file_ff) < (FILE_W + 1)'(FILES));
   assign req_win = (CURSOR_W'(req_position) < CURSOR_W'(limit))
                 && ((FILE_W + 1)'(req_file_index) < (FILE_W + 1)'(FILES));

   assign req_stall = clr_active_ff || (s2_op_ff == S2_READ) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_quality_ff   <= '0;
         region_length_ff <= REGION_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_QUALITY:   min_quality_ff   <= csr_write_data[QUAL_W-1:0];
            CSR_REGION_LENGTH: region_length_ff <= csr_write_data[REGION_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cursor_in       = cursor_ff;
      read_file_in    = read_file_ff;
      read_skipped_in = read_skipped_ff;
      op_kind_in      = op_kind_ff;
      op_remaining_in = op_remaining_ff;
      s2_op_in        = S2_NONE;
      s2_row_in       = s2_row_ff;
      s2_lane_in      = s2_lane_ff;
      s2_win_in       = s2_win_ff;
      if (accept) begin
         case (req_mode)
            MODE_START: begin
               read_file_in    = req_file_index;
               cursor_in       = CURSOR_W'(req_position);
               read_skipped_in = (req_map_quality < min_quality_ff)
                              || ((FILE_W + 1)'(req_file_index) >= (FILE_W + 1)'(FILES));
               op_kind_in      = CIG_M;
               op_remaining_in = '0;
            end
            MODE_CIGAR: begin
               cursor_in = cursor_ff
                         + (is_match(op_kind_ff) ? CURSOR_W'(op_remaining_ff) : '0)
                         + ((req_cigar_code inside {CIG_D, CIG_N})
                            ? CURSOR_W'(req_op_length) : '0);
               op_kind_in = req_cigar_code;
               op_remaining_in = (is_match(req_cigar_code)
                                  || (req_cigar_code inside {CIG_I, CIG_S}))
                                 ? req_op_length : '0;
            end
            MODE_BASE: begin
               if (op_remaining_ff != '0) begin
                  op_remaining_in = op_remaining_ff - OPLEN_W'(1);
                  if (is_match(op_kind_ff)) begin
                     if (!read_skipped_ff && cur_win) begin
                        s2_op_in   = S2_INC;
                        s2_row_in  = row_of(cursor_ff, read_file_ff);
                        s2_lane_in = base_lane(req_base_code);
                     end
                     cursor_in = cursor_ff + CURSOR_W'(1);
                  end
               end
            end
            MODE_READ: begin
               s2_op_in  = S2_READ;
               s2_win_in = req_win;
               s2_row_in = row_of(CURSOR_W'(req_position), req_file_index);
            end
            MODE_CLEAR: begin
               if (req_win) begin
                  s2_op_in  = S2_CLEAR;
                  s2_row_in = row_of(CURSOR_W'(req_position), req_file_index);
               end
            end
            default: ;
         endcase
      end
      rd_en     = (s2_op_in == S2_INC) || (s2_op_in == S2_READ);
      s2_fwd_in = ((s2_op_ff == S2_INC) || (s2_op_ff == S2_CLEAR)) && (s2_row_ff == s2_row_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff       <= '0;
         read_file_ff    <= '0;
         read_skipped_ff <= 1'b1;
         op_kind_ff      <= CIG_M;
         op_remaining_ff <= '0;
         s2_op_ff        <= S2_NONE;
      end else begin
         cursor_ff       <= cursor_in;
         read_file_ff    <= read_file_in;
         read_skipped_ff <= read_skipped_in;
         op_kind_ff      <= op_kind_in;
         op_remaining_ff <= op_remaining_in;
         s2_op_ff        <= s2_op_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_row_ff  <= s2_row_in;
      s2_lane_ff <= s2_lane_in;
      s2_win_ff  <= s2_win_in;
      s2_fwd_ff  <= s2_fwd_in;
      last_wr_ff <= wr_data;
   end

   always_comb begin
      row_cur = s2_fwd_ff ? last_wr_ff : rd_data;
      for (int i = 0; i < NCOUNTS; i++) begin
         row_new[i] = row_cur[i] + ((LANE_W'(i) == s2_lane_ff) ? CNT_W'(1) : CNT_W'(0));
      end
      wr_en   = clr_active_ff || (s2_op_ff == S2_INC) || (s2_op_ff == S2_CLEAR);
      wr_addr = clr_active_ff ? clr_row_ff : s2_row_ff;
      wr_data = (clr_active_ff || (s2_op_ff == S2_CLEAR)) ? '0 : row_new;
   end

   assign clr_row_in    = clr_row_ff + ROW_W'(1);
   assign clr_active_in = clr_active_ff && (clr_row_ff != ROW_W'(ROWS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_row_ff    <= '0;
      end else if (clr_active_ff) begin
         clr_active_ff <= clr_active_in;
         clr_row_ff    <= clr_row_in;
      end
   end

   abdc_count_ram #(
      .DEPTH (ROWS),
      .WIDTH (ROW_BITS),
      .ADDR_W(ROW_W)
   ) u_count_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(s2_row_in),
      .rd_data(rd_data)
   );

   assign rsp_valid_in = (s2_op_ff == S2_READ) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_op_ff == S2_READ) begin
         rsp_row_ff <= s2_win_ff ? row_cur : '0;
         rsp_win_ff <= s2_win_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_a     = rsp_row_ff[LANE_A];
   assign rsp_count_t     = rsp_row_ff[LANE_T];
   assign rsp_count_c     = rsp_row_ff[LANE_C];
   assign rsp_count_g     = rsp_row_ff[LANE_G];
   assign rsp_count_n     = rsp_row_ff[LANE_N];
   assign rsp_count_other = rsp_row_ff[LANE_OTHER];
   assign rsp_in_window   = rsp_win_ff;

endmodule

### rtl/core/abdc_checker.sv
module abdc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [abdc_pkg::MODE_W-1:0] req_mode,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [abdc_pkg::CNT_W-1:0] rsp_count_a,
   input logic [abdc_pkg::CNT_W-1:0] rsp_count_t,
   input logic [abdc_pkg::CNT_W-1:0] rsp_count_c,
   input logic [abdc_pkg::CNT_W-1:0] rsp_count_g,
   input logic [abdc_pkg::CNT_W-1:0] rsp_count_n,
   input logic [abdc_pkg::CNT_W-1:0] rsp_count_other,
   input logic                       rsp_in_window
);

   import abdc_pkg::*;

   logic read_accept;

   assign read_accept = req_valid && !req_stall && (req_mode == MODE_READ);

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(read_accept, 2))
      else $error("response without a count read two cycles earlier");

   a_read_holds_req: assert property (@(posedge clock) disable iff (reset)
      read_accept |=> req_stall)
      else $error("request side not held behind a count read");

   a_out_of_window_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_window) |-> (rsp_count_a == '0 && rsp_count_t == '0
         && rsp_count_c == '0 && rsp_count_g == '0 && rsp_count_n == '0
         && rsp_count_other == '0))
      else $error("nonzero counts outside the window");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_count_a)
         && $stable(rsp_count_t) && $stable(rsp_count_c) && $stable(rsp_count_g)
         && $stable(rsp_count_n) && $stable(rsp_count_other)
         && $stable(rsp_in_window)))
      else $error("stalled response changed");

endmodule

bind aligned_base_depth_counter_unit abdc_checker u_abdc_checker (.*);

### bench/tb_aligned_base_depth_counter_unit.sv
`timescale 1ns / 100ps

module tb_aligned_base_depth_counter_unit;
   import abdc_pkg::*;

   localparam int CLOCK_HALF    = 2;
   localparam int RESET_CYCLES  = 8;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic [MODE_W-1:0]  MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_W-1:0]  MODE_SPARE_HI = 3'd7;
   localparam logic [CIGAR_W-1:0] CIG_H         = 4'd5;
   localparam logic [CIGAR_W-1:0] CIG_P         = 4'd6;
   localparam logic [CIGAR_W-1:0] CIG_LAST      = 4'd15;
   localparam logic [BASE_W-1:0]  BASE_EQ       = 4'd0;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [FILE_W-1:0]  file_index;
      logic [POS_W-1:0]   position;
      logic [QUAL_W-1:0]  map_quality;
      logic [CIGAR_W-1:0] cigar_code;
      logic [OPLEN_W-1:0] op_length;
      logic [BASE_W-1:0]  base_code;
   } req_item_type;

   typedef struct packed {
      logic [CNT_W-1:0] count_a;
      logic [CNT_W-1:0] count_t;
      logic [CNT_W-1:0] count_c;
      logic [CNT_W-1:0] count_g;
      logic [CNT_W-1:0] count_n;
      logic [CNT_W-1:0] count_other;
      logic             in_window;
   } depth_row_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [MODE_W-1:0]     req_mode         = '0;
   logic [FILE_W-1:0]     req_file_index   = '0;
   logic [POS_W-1:0]      req_position     = '0;
   logic [QUAL_W-1:0]     req_map_quality  = '0;
   logic [CIGAR_W-1:0]    req_cigar_code   = '0;
   logic [OPLEN_W-1:0]    req_op_length    = '0;
   logic [BASE_W-1:0]     req_base_code    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [CNT_W-1:0]      rsp_count_a;
   logic [CNT_W-1:0]      rsp_count_t;
   logic [CNT_W-1:0]      rsp_count_c;
   logic [CNT_W-1:0]      rsp_count_g;
   logic [CNT_W-1:0]      rsp_count_n;
   logic [CNT_W-1:0]      rsp_count_other;
   logic                  rsp_in_window;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;

   bit [CNT_W-1:0]    base_tally [ROWS][NCOUNTS];
   bit [CURSOR_W-1:0] cursor;
   bit [FILE_W-1:0]   cur_file;
   bit                skip_read  = 1'b1;
   bit [CIGAR_W-1:0]  cur_op;
   bit [OPLEN_W-1:0]  op_left;
   bit [QUAL_W-1:0]   qual_floor;
   bit [REGION_W-1:0] span_now   = REGION_RESET;
   depth_row_type     reads_due [$];

   int idle_pct   = 0;
   int stall_pct  = 0;
   int items_sent = 0;
   int mismatches = 0;
   int cycles     = 0;

   aligned_base_depth_counter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_file_index   (req_file_index),
      .req_position     (req_position),
      .req_map_quality  (req_map_quality),
      .req_cigar_code   (req_cigar_code),
      .req_op_length    (req_op_length),
      .req_base_code    (req_base_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_count_a      (rsp_count_a),
      .rsp_count_t      (rsp_count_t),
      .rsp_count_c      (rsp_count_c),
      .rsp_count_g      (rsp_count_g),
      .rsp_count_n      (rsp_count_n),
      .rsp_count_other  (rsp_count_other),
      .rsp_in_window    (rsp_in_window),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #CLOCK_HALF clock = ~clock;

   function automatic bit match_kind(bit [CIGAR_W-1:0] code);
      return code == CIG_M || code == CIG_EQ || code == CIG_X;
   endfunction

   function automatic int window_limit();
      return (int'(span_now) > WINDOW) ? WINDOW : int'(span_now);
   endfunction

   function automatic bit inside_window(bit [CURSOR_W-1:0] pos, bit [FILE_W-1:0] file);
      return pos < CURSOR_W'(window_limit()) && int'(file) < FILES;
   endfunction

   function automatic int lane_of(bit [BASE_W-1:0] code);
      case (code)
         BASE_A:  return LANE_A;
         BASE_T:  return LANE_T;
         BASE_C:  return LANE_C;
         BASE_G:  return LANE_G;
         BASE_N:  return LANE_N;
         default: return LANE_OTHER;
      endcase
   endfunction

   function automatic void pileup_step(req_item_type it);
      int            row;
      depth_row_type got;
      case (it.mode)
         MODE_START: begin
            cur_file  = it.file_index;
            cursor    = CURSOR_W'(it.position);
            skip_read = it.map_quality < qual_floor || int'(it.file_index) >= FILES;
            cur_op    = CIG_M;
            op_left   = '0;
         end
         MODE_CIGAR: begin
            // skip over bases still owed by a match op cut short
            if (match_kind(cur_op)) cursor += CURSOR_W'(op_left);
            cur_op = it.cigar_code;
            if (it.cigar_code == CIG_D || it.cigar_code == CIG_N) begin
               cursor += CURSOR_W'(it.op_length);
               op_left = '0;
            end else if (match_kind(it.cigar_code) || it.cigar_code == CIG_I ||
                         it.cigar_code == CIG_S) begin
               op_left = it.op_length;
            end else begin
               op_left = '0;
            end
         end
         MODE_BASE: begin
            if (op_left != '0) begin
               op_left--;
               if (match_kind(cur_op)) begin
                  if (!skip_read && inside_window(cursor, cur_file)) begin
                     row = int'(cursor) * FILES + int'(cur_file);
                     base_tally[row][lane_of(it.base_code)]++;
                  end
                  cursor++;
               end
            end
         end
         MODE_READ: begin
            got = '0;
            if (inside_window(CURSOR_W'(it.position), it.file_index)) begin
               row             = int'(it.position) * FILES + int'(it.file_index);
               got.count_a     = base_tally[row][LANE_A];
               got.count_t     = base_tally[row][LANE_T];
               got.count_c     = base_tally[row][LANE_C];
               got.count_g     = base_tally[row][LANE_G];
               got.count_n     = base_tally[row][LANE_N];
               got.count_other = base_tally[row][LANE_OTHER];
               got.in_window   = 1'b1;
            end
            reads_due = {reads_due, got};
         end
         MODE_CLEAR: begin
            if (inside_window(CURSOR_W'(it.position), it.file_index)) begin
               row = int'(it.position) * FILES + int'(it.file_index);
               for (int k = 0; k < NCOUNTS; k++) base_tally[row][k] = '0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                       logic [CNT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      depth_row_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reads_due.size() == 0) begin
            $error("count item with no read pending");
            mismatches++;
         end else begin
            want = reads_due.pop_front();
            check_field("count_a", want.count_a, rsp_count_a);
            check_field("count_t", want.count_t, rsp_count_t);
            check_field("count_c", want.count_c, rsp_count_c);
            check_field("count_g", want.count_g, rsp_count_g);
            check_field("count_n", want.count_n, rsp_count_n);
            check_field("count_other", want.count_other, rsp_count_other);
            check_field("in_window", CNT_W'(want.in_window), CNT_W'(rsp_in_window));
         end
      end
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL aligned_base_depth_counter_unit");
         $finish;
      end
   end

   task automatic send_item(req_item_type it);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= it.mode;
      req_file_index  <= it.file_index;
      req_position    <= it.position;
      req_map_quality <= it.map_quality;
      req_cigar_code  <= it.cigar_code;
      req_op_length   <= it.op_length;
      req_base_code   <= it.base_code;
      do @(posedge clock); while (req_stall);
      pileup_step(it);
      if (it.mode <= MODE_CLEAR) items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (reads_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(logic [QUAL_W-1:0] floor_q, logic [REGION_W-1:0] span);
      logic [CSR_DATA_W-1:0] data;
      data               = CSR_DATA_W'($urandom);
      data[QUAL_W-1:0]   = floor_q;
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MIN_QUALITY;
      csr_write_data   <= data;
      @(posedge clock);
      qual_floor        = floor_q;
      csr_index        <= CSR_REGION_LENGTH;
      csr_write_data   <= CSR_DATA_W'(span);
      @(posedge clock);
      span_now          = span;
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_item_type noise_item();
      req_item_type it;
      it.mode        = MODE_W'($urandom);
      it.file_index  = FILE_W'($urandom);
      it.position    = POS_W'($urandom);
      it.map_quality = QUAL_W'($urandom);
      it.cigar_code  = CIGAR_W'($urandom);
      it.op_length   = OPLEN_W'($urandom);
      it.base_code   = BASE_W'($urandom);
      return it;
   endfunction

   task automatic send_start(logic [FILE_W-1:0] file, logic [POS_W-1:0] pos,
                             logic [QUAL_W-1:0] qual);
      req_item_type it;
      it             = noise_item();
      it.mode        = MODE_START;
      it.file_index  = file;
      it.position    = pos;
      it.map_quality = qual;
      send_item(it);
   endtask

   task automatic send_cigar(logic [CIGAR_W-1:0] code, logic [OPLEN_W-1:0] len);
      req_item_type it;
      it            = noise_item();
      it.mode       = MODE_CIGAR;
      it.cigar_code = code;
      it.op_length  = len;
      send_item(it);
   endtask

   task automatic send_base(logic [BASE_W-1:0] code);
      req_item_type it;
      it           = noise_item();
      it.mode      = MODE_BASE;
      it.base_code = code;
      send_item(it);
   endtask

   task automatic send_query(logic [MODE_W-1:0] mode, logic [FILE_W-1:0] file,
                             logic [POS_W-1:0] pos);
      req_item_type it;
      it            = noise_item();
      it.mode       = mode;
      it.file_index = file;
      it.position   = pos;
      send_item(it);
   endtask

   function automatic logic [QUAL_W-1:0] pick_quality();
      if (qual_floor != '0 && $urandom_range(6) == 0)
         return QUAL_W'($urandom_range(int'(qual_floor) - 1));
      return QUAL_W'($urandom_range(2 ** QUAL_W - 1, int'(qual_floor)));
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      if ($urandom_range(4) == 0) return POS_W'($urandom);
      return POS_W'($urandom_range(window_limit() + 8));
   endfunction

   function automatic logic [CIGAR_W-1:0] pick_cigar();
      case ($urandom_range(19))
         0, 1, 2, 3, 4: return CIG_M;
         5, 6:          return CIG_EQ;
         7, 8:          return CIG_X;
         9, 10:         return CIG_I;
         11, 12:        return CIG_S;
         13, 14:        return CIG_D;
         15:            return CIG_N;
         16:            return CIG_H;
         17:            return CIG_P;
         default:       return CIGAR_W'($urandom_range(CIG_LAST, CIG_X + 1));
      endcase
   endfunction

   function automatic logic [BASE_W-1:0] pick_base();
      case ($urandom_range(6))
         0:       return BASE_A;
         1:       return BASE_C;
         2:       return BASE_G;
         3:       return BASE_T;
         4:       return BASE_N;
         default: return BASE_W'($urandom);
      endcase
   endfunction

   task automatic send_read();
      logic [POS_W-1:0]   start;
      logic [FILE_W-1:0]  file;
      logic [CIGAR_W-1:0] code;
      logic [OPLEN_W-1:0] len;
      int                 bases;
      start = pick_position();
      file  = FILE_W'($urandom);
      send_start(file, start, pick_quality());
      repeat ($urandom_range(4, 1)) begin
         code = pick_cigar();
         len  = ($urandom_range(9) == 0) ? OPLEN_W'($urandom) : OPLEN_W'($urandom_range(6));
         send_cigar(code, len);
         bases = 0;
         if (match_kind(code) || code == CIG_I || code == CIG_S)
            bases = (len > 8) ? 8 : int'(len);
         if ($urandom_range(9) == 0) bases = $urandom_range(bases);
         if ($urandom_range(9) == 0) bases++;
         repeat (bases) send_base(pick_base());
      end
      repeat ($urandom_range(2)) begin
         send_query(MODE_READ, ($urandom_range(4) == 0) ? FILE_W'($urandom) : file,
                    start + POS_W'($urandom_range(10)));
      end
      if ($urandom_range(7) == 0)
         send_query(MODE_CLEAR, file, start + POS_W'($urandom_range(10)));
   endtask

   task automatic test_match_counting();
      send_start(2'd3, POS_W'(WINDOW - 2), 8'd30);
      send_cigar(CIG_M, 28'd3);
      send_base(BASE_A);
      send_base(BASE_N);
      send_base(BASE_EQ);
      send_base(BASE_T);
      send_query(MODE_READ, 2'd3, POS_W'(WINDOW - 2));
      send_query(MODE_READ, 2'd3, POS_W'(WINDOW - 1));
      send_query(MODE_READ, 2'd3, POS_W'(WINDOW));
   endtask

   task automatic test_cigar_kinds();
      send_start(2'd1, 31'd10, {QUAL_W{1'b1}});
      send_cigar(CIG_S, 28'd1);
      send_base(BASE_C);
      send_cigar(CIG_EQ, 28'd4);
      send_base(BASE_G);
      send_cigar(CIG_I, 28'd1);
      send_base(BASE_T);
      send_cigar(CIG_N, 28'd2);
      send_cigar(CIG_H, {OPLEN_W{1'b1}});
      send_cigar(CIG_P, 28'd1);
      send_cigar(CIG_LAST, 28'd5);
      send_base(BASE_A);
      send_cigar(CIG_D, 28'd3);
      send_cigar(CIG_X, 28'd1);
      send_base(BASE_W'(4'd14));
      send_query(MODE_READ, 2'd1, 31'd10);
      send_query(MODE_READ, 2'd1, 31'd19);
   endtask

   task automatic test_skipped_read();
      send_start(2'd0, 31'd0, 8'd29);
      send_cigar(CIG_X, 28'd1);
      send_base(BASE_A);
      send_query(MODE_READ, 2'd0, 31'd0);
   endtask

   task automatic test_clear_edges();
      send_query(MODE_CLEAR, 2'd3, POS_W'(WINDOW - 2));
      send_query(MODE_READ, 2'd3, POS_W'(WINDOW - 2));
      send_query(MODE_CLEAR, 2'd3, {POS_W{1'b1}});
      send_query(MODE_READ, 2'd3, {POS_W{1'b1}});
   endtask

   task automatic test_unused_modes();
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) send_query(MODE_W'(m), 2'd0, 31'd0);
      send_query(MODE_READ, 2'd1, 31'd10);
   endtask

   task automatic run_phase(int idle, int stall, logic [QUAL_W-1:0] floor_q,
                            logic [REGION_W-1:0] span, int count);
      int target;
      drain();
      set_config(floor_q, span);
      idle_pct  = idle;
      stall_pct = stall;
      target    = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(9) == 0) send_item(noise_item());
         else send_read();
      end
   endtask

   task automatic test_random_pileup();
      run_phase(0, 0, '0, REGION_RESET, 250);
      run_phase(77, 0, {QUAL_W{1'b1}}, 13'd16, 250);
      run_phase(0, 77, QUAL_W'($urandom_range(40)), 13'd1, 250);
      run_phase(29, 29, 8'd20, 13'd0, 250);
      run_phase(0, 0, 8'd10, {REGION_W{1'b1}}, 250);
      run_phase(77, 0, QUAL_W'($urandom), REGION_W'($urandom_range(300, 16)), 250);
      run_phase(0, 77, QUAL_W'($urandom_range(60)), REGION_W'($urandom_range(64, 8)), 250);
      run_phase(29, 29, '0, 13'd64, 250);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      set_config(8'd30, REGION_RESET);
      test_match_counting();
      test_cigar_kinds();
      test_skipped_read();
      test_clear_edges();
      test_unused_modes();
      test_random_pileup();
      drain();
      if (mismatches == 0) begin
         $display("PASS aligned_base_depth_counter_unit");
      end else begin
         $display("FAIL aligned_base_depth_counter_unit");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/abdc_pkg.sv
rtl/core/abdc_count_ram.sv
rtl/core/aligned_base_depth_counter_unit.sv
rtl/core/abdc_checker.sv
bench/tb_aligned_base_depth_counter_unit.sv
